// ===== rtl/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg: shared definitions for the multichannel moving average
// Sizes, field layout of the stream words and the control/status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

  // Block configuration.
  localparam int CHANNELS    = 4;
  localparam int MAX_WINDOW  = 16;
  localparam int SAMPLE_BITS = 12;

  // Fixed field widths of the stream items.
  localparam int CH_IN_W  = 3;
  localparam int SMP_IN_W = 12;
  localparam int WIN_IN_W = 5;
  localparam int AVG_W    = 12;

  // Bit offsets inside the input tdata word.
  localparam int CH_LSB  = 0;
  localparam int SMP_LSB = CH_LSB + CH_IN_W;
  localparam int WIN_LSB = SMP_LSB + SMP_IN_W;
  localparam int IN_W    = WIN_LSB + WIN_IN_W;

  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((AVG_W + 7) / 8) * 8;

  // Derived storage sizes.
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int SLOT_W    = $clog2(MAX_WINDOW);
  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W     = SAMPLE_BITS + SLOT_W;
  localparam int ADDR_W    = CH_W + SLOT_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  // Window used when the request is zero or too large.
  localparam int DEFAULT_WINDOW = 4;
  localparam int DEF_WIN = (DEFAULT_WINDOW <= MAX_WINDOW) ? DEFAULT_WINDOW : MAX_WINDOW;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the incoming item
    logic write;      // store the sample and update the fill count
    logic sum_run;    // step the ring summation and the slot wrap
    logic div_start;  // commit the new slot and start the divider
    logic out_load;   // load the output register
  } mma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;     // latched channel is out of range
    logic sum_done;   // all filled entries have been added
    logic mod_done;   // next slot is below the window
    logic div_done;   // quotient is ready
  } mma_sts_t;

endpackage

`default_nettype wire

// ===== rtl/multichannel_moving_average.sv =====
// ----------------------------------------------------------------------------
// multichannel_moving_average: per-channel moving average of converter samples
// Each item for a valid channel writes a sample into its ring and returns the
// truncated mean of the filled ring entries; other channels return zero.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bits first)
//  s_*       in         channel[2:0], sample[14:3], window_request[19:15]
//  m_*       out        average[11:0]
//
//  An item for a valid channel is accepted and latched, then stored; then one
//  read is issued per filled entry, the reads drain and the divider starts,
//  the bit-serial divider runs, and the output is loaded. The slot wrap
//  subtracts the window once per cycle beside the reads; after a window
//  shrinks it can stretch the summation. An out-of-range channel skips the
//  store, summation and division and goes straight to the output load.
//  Reset clears slots, fill counts and the valid bits of the sample store at
//  once; no clearing pass follows. One item is in work at a time; the next is
//  taken while a finished result waits, and a stalled output only holds the
//  block once the following result is ready.
//
`default_nettype none

module multichannel_moving_average
  import mma_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Input item: channel[2:0], sample[14:3], window_request[19:15], zero pad.
  input  wire logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  wire logic                   s_tvalid_i,
  output logic                        s_tready_o,
  // Result item: average[11:0], zero pad.
  output logic      [OUT_TDATA_W-1:0] m_tdata_o,
  output logic                        m_tvalid_o,
  input  wire logic                   m_tready_i
);

  mma_cmd_t         cmd;
  mma_sts_t         sts;
  logic [AVG_W-1:0] average;

  // The controller only walks the phases; all arithmetic and storage sit in
  // the datapath.
  mma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The fields are taken straight from the input word; the datapath latches
  // them when the controller accepts the item.
  mma_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .channel_i (s_tdata_i[CH_LSB +: CH_IN_W]),
    .sample_i  (s_tdata_i[SMP_LSB +: SMP_IN_W]),
    .window_i  (s_tdata_i[WIN_LSB +: WIN_IN_W]),
    .average_o (average)
  );

  // The average sits in the low bits; the rest of the word is zero.
  assign m_tdata_o = OUT_TDATA_W'(average);

endmodule

`default_nettype wire

// ===== rtl/mma_div.sv =====
// ----------------------------------------------------------------------------
// mma_div: iterative restoring divider
// Divides the window sum by the fill count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_div
  import mma_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output logic      [SUM_W-1:0] quotient_o,
  output logic                  done_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = STEP_W'(SUM_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits CNT_W bits.
      rem_d  = fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
      quo_d  = {quo_q[SUM_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

  // A new division is never started on top of one still in progress.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ===== rtl/mma_dp.sv =====
// ----------------------------------------------------------------------------
// mma_dp: datapath of the multichannel moving average
// Holds the sample rings, slot and fill counters, sums a channel's ring one
// entry per cycle and divides the sum by the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_dp
  import mma_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mma_cmd_t            cmd_i,
  output mma_sts_t                 sts_o,
  input  wire logic [CH_IN_W-1:0]  channel_i,
  input  wire logic [SMP_IN_W-1:0] sample_i,
  input  wire logic [WIN_IN_W-1:0] window_i,
  output logic      [AVG_W-1:0]    average_o
);

  // Latched item.
  logic [CH_IN_W-1:0]     ch_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [CNT_W-1:0]       win_q;
  logic                   reject_q;
  logic [CNT_W-1:0]       win_pick;

  // Per-channel ring state.
  logic [SLOT_W-1:0] wslot_q [CHANNELS];
  logic [CNT_W-1:0]  fill_q [CHANNELS];

  // Sample store with one valid bit per entry; an unwritten entry adds nothing to the sum.
  logic [SAMPLE_BITS-1:0] store_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]   valid_q;
  logic [SAMPLE_BITS-1:0] rdata_q;
  logic                   rvalid_q;

  // Summation and slot wrap.
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic             rd_pend_q;
  logic [SUM_W-1:0] acc_q;
  logic [CNT_W-1:0] rem_q;

  logic [CH_W-1:0]   chx;
  logic [SLOT_W-1:0] slot_cur;
  logic [CNT_W-1:0]  fill_cur;
  logic [CNT_W-1:0]  fill_new;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic              rd_en;

  logic [SUM_W-1:0] quotient;
  logic             div_done;
  logic [AVG_W-1:0] avg_q;

  always_comb begin
    if (window_i == '0 || 32'(window_i) > MAX_WINDOW) begin
      win_pick = CNT_W'(DEF_WIN);
    end else begin
      win_pick = CNT_W'(window_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_q <= 1'b0;
    end else if (cmd_i.load) begin
      reject_q <= (32'(channel_i) >= CHANNELS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q  <= channel_i;
      smp_q <= SAMPLE_BITS'(sample_i);
      win_q <= win_pick;
    end
  end

  assign chx      = ch_q[CH_W-1:0];
  assign slot_cur = (32'(wslot_q[chx]) >= MAX_WINDOW) ? '0 : wslot_q[chx];
  assign fill_cur = fill_q[chx];
  assign fill_new = (fill_cur < win_q) ? fill_cur + CNT_W'(1) : fill_cur;
  assign waddr    = {chx, slot_cur};
  assign raddr    = {chx, idx_q[SLOT_W-1:0]};
  assign rd_en    = cmd_i.sum_run && (idx_q < cnt_q);

  // Ring counters: the fill count moves with the write, the slot once the
  // wrap has settled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wslot_q[c] <= '0;
        fill_q[c]  <= '0;
      end
      valid_q <= '0;
    end else begin
      if (cmd_i.write) begin
        fill_q[chx]    <= fill_new;
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.div_start) begin
        wslot_q[chx] <= rem_q[SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      store_q[waddr] <= smp_q;
    end
    if (rd_en) begin
      rdata_q  <= store_q[raddr];
      rvalid_q <= valid_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
    end else if (cmd_i.write) begin
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
    end else if (cmd_i.sum_run) begin
      if (rd_en) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      rd_pend_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      cnt_q <= fill_new;
      acc_q <= '0;
      rem_q <= CNT_W'(slot_cur) + CNT_W'(1);
    end else if (cmd_i.sum_run) begin
      if (rd_pend_q && rvalid_q) begin
        acc_q <= acc_q + SUM_W'(rdata_q);
      end
      if (rem_q >= win_q) begin
        rem_q <= rem_q - win_q;
      end
    end
  end

  mma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .divisor_i  (cnt_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      avg_q <= reject_q ? '0 : AVG_W'(quotient);
    end
  end

  assign average_o       = avg_q;
  assign sts_o.reject    = reject_q;
  assign sts_o.sum_done  = (idx_q == cnt_q) && !rd_pend_q;
  assign sts_o.mod_done  = (rem_q < win_q);
  assign sts_o.div_done  = div_done;

  // The divider only starts once the sum and the next slot are settled.
  a_div_after_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (sts_o.sum_done && sts_o.mod_done))
    else $error("divider started before sum and slot wrap finished");

  // After a store the fill count is never zero, so the divisor is valid.
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |=> (cnt_q != '0))
    else $error("zero fill count after a write");

endmodule

`default_nettype wire

// ===== rtl/mma_ctrl.sv =====
// ----------------------------------------------------------------------------
// mma_ctrl: controller of the multichannel moving average
// Sequences latch, store, summation, division and output of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_ctrl
  import mma_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_tvalid_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  wire logic     m_tready_i,
  input  wire mma_sts_t sts_i,
  output mma_cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WRITE  = 3'd1;
  localparam logic [2:0] ST_SUM    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    s_tready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (sts_i.reject) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.write = 1'b1;
          state_d     = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum_run = 1'b1;
        if (sts_i.sum_done && sts_i.mod_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

  // A result is never loaded in a cycle that can take a new item.
  a_load_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !cmd_o.out_load)
    else $error("output loaded while idle");

  // Starting the divider clears its done flag in the following cycle.
  a_div_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !sts_i.div_done)
    else $error("stale divider done seen after start");

endmodule

`default_nettype wire
